// File: rtl/c8eu_pkg.sv
// Shared types and constants of the CHIP-8 execute unit.
package c8eu_pkg;

  // Operation codes of the decoded instruction; codes 30 and 31 only advance the PC.
  typedef enum logic [4:0] {
    FN_RET      = 5'd0,
    FN_JP       = 5'd1,
    FN_CALL     = 5'd2,
    FN_SE_IMM   = 5'd3,
    FN_SNE_IMM  = 5'd4,
    FN_SE       = 5'd5,
    FN_LD_IMM   = 5'd6,
    FN_ADD_IMM  = 5'd7,
    FN_MOV      = 5'd8,
    FN_OR       = 5'd9,
    FN_AND      = 5'd10,
    FN_XOR      = 5'd11,
    FN_ADD      = 5'd12,
    FN_SUB      = 5'd13,
    FN_SHR      = 5'd14,
    FN_SUBN     = 5'd15,
    FN_SHL      = 5'd16,
    FN_SNE      = 5'd17,
    FN_LD_I     = 5'd18,
    FN_JP_OFF   = 5'd19,
    FN_RND      = 5'd20,
    FN_SKP      = 5'd21,
    FN_SKNP     = 5'd22,
    FN_GET_DT   = 5'd23,
    FN_SET_DT   = 5'd24,
    FN_SET_ST   = 5'd25,
    FN_ADD_I    = 5'd26,
    FN_FONT     = 5'd27,
    FN_BIG_FONT = 5'd28,
    FN_EXIT     = 5'd29
  } func_t;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_DELAY = 2'd1,
    TMR_SOUND = 2'd2
  } timer_sel_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOGIC_CLEARS_FLAG   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_USES_SECOND   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_JUMP_USES_VX = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ADDRESS       = 2'd3;

  localparam logic [15:0] START_ADDRESS_RESET = 16'd512;

  localparam logic [3:0]  VF_INDEX        = 4'hF;
  localparam logic [3:0]  V0_INDEX        = 4'h0;
  localparam logic [7:0]  KEY_COUNT       = 8'd16;
  localparam logic [15:0] PC_STEP         = 16'd2;
  localparam logic [15:0] FONT_STRIDE     = 16'd5;
  localparam logic [15:0] BIG_FONT_STRIDE = 16'd10;
  localparam logic [15:0] BIG_FONT_BASE   = 16'd80;

  // One decoded instruction with its side operands.
  typedef struct packed {
    logic [4:0]  func;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic [7:0]  dly;
  } instr_t;

  typedef struct packed {
    logic logic_clears_flag;
    logic shift_uses_second;
  } quirk_t;

  // Register values the instruction sees.
  typedef struct packed {
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  vj;
    logic [15:0] pc;
    logic [15:0] index;
    logic [15:0] pop_pc;
  } operands_t;

  // State updates the instruction asks for.
  typedef struct packed {
    logic [15:0] pc_next;
    logic [15:0] index_next;
    logic        x_we;
    logic [7:0]  x_data;
    logic        f_we;
    logic [7:0]  f_data;
    logic        push;
    logic [15:0] push_data;
    logic        pop;
    logic        halt_set;
    timer_sel_t  timer_write;
    logic [7:0]  timer_value;
  } exec_t;

endpackage

// File: rtl/c8eu_ifs.sv
// Valid/ready channel interfaces for instructions and results.
interface c8eu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [3:0]  first_reg;
  logic [3:0]  second_reg;
  logic [7:0]  imm_byte;
  logic [11:0] target_addr;
  logic [7:0]  random_byte;
  logic [15:0] key_mask;
  logic [7:0]  delay_now;

  modport source (
    output valid, func, first_reg, second_reg, imm_byte, target_addr, random_byte,
           key_mask, delay_now,
    input  ready
  );
  modport sink (
    input  valid, func, first_reg, second_reg, imm_byte, target_addr, random_byte,
           key_mask, delay_now,
    output ready
  );
endinterface

interface c8eu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [15:0] index_value;
  logic [7:0]  dest_value;
  logic [7:0]  flag_value;
  logic [1:0]  timer_write;
  logic [7:0]  timer_value;
  logic        halted;

  modport source (
    output valid, next_pc, index_value, dest_value, flag_value, timer_write, timer_value,
           halted,
    input  ready
  );
  modport sink (
    input  valid, next_pc, index_value, dest_value, flag_value, timer_write, timer_value,
           halted,
    output ready
  );
endinterface

// File: rtl/c8eu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c8eu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/c8eu_alu.sv
// Instruction decode and datapath: turns one instruction and its operands into state updates.
module c8eu_alu (
  input  c8eu_pkg::instr_t    instr,
  input  c8eu_pkg::operands_t opnd,
  input  c8eu_pkg::quirk_t    quirk,
  output c8eu_pkg::exec_t     ex
);

  c8eu_pkg::func_t fn;
  logic [15:0] pc_adv;
  logic [15:0] pc_skip;
  logic [7:0]  shift_src;
  logic [8:0]  sum;
  logic        key_held;
  logic [7:0]  logic_res;

  assign fn        = c8eu_pkg::func_t'(instr.func);
  assign pc_adv    = opnd.pc + c8eu_pkg::PC_STEP;
  assign pc_skip   = pc_adv + c8eu_pkg::PC_STEP;
  assign shift_src = quirk.shift_uses_second ? opnd.vy : opnd.vx;
  assign sum       = {1'b0, opnd.vx} + {1'b0, opnd.vy};
  assign key_held  = (opnd.vx < c8eu_pkg::KEY_COUNT) && instr.keys[opnd.vx[3:0]];
  assign logic_res = (fn == c8eu_pkg::FN_OR)  ? (opnd.vx | opnd.vy) :
                     (fn == c8eu_pkg::FN_AND) ? (opnd.vx & opnd.vy) :
                                                (opnd.vx ^ opnd.vy);

  always_comb begin
    ex             = '0;
    ex.pc_next     = pc_adv;
    ex.index_next  = opnd.index;
    ex.push_data   = pc_adv;
    ex.timer_write = c8eu_pkg::TMR_NONE;

    unique case (fn) inside
      c8eu_pkg::FN_RET: begin
        ex.pop     = 1'b1;
        ex.pc_next = opnd.pop_pc;
      end
      c8eu_pkg::FN_JP: begin
        ex.pc_next = {4'd0, instr.nnn};
      end
      c8eu_pkg::FN_CALL: begin
        ex.push    = 1'b1;
        ex.pc_next = {4'd0, instr.nnn};
      end
      c8eu_pkg::FN_SE_IMM: begin
        if (opnd.vx == instr.kk) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_SNE_IMM: begin
        if (opnd.vx != instr.kk) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_SE: begin
        if (opnd.vx == opnd.vy) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_SNE: begin
        if (opnd.vx != opnd.vy) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_LD_IMM: begin
        ex.x_we   = 1'b1;
        ex.x_data = instr.kk;
      end
      c8eu_pkg::FN_ADD_IMM: begin
        ex.x_we   = 1'b1;
        ex.x_data = opnd.vx + instr.kk;
      end
      c8eu_pkg::FN_MOV: begin
        ex.x_we   = 1'b1;
        ex.x_data = opnd.vy;
      end
      c8eu_pkg::FN_OR, c8eu_pkg::FN_AND, c8eu_pkg::FN_XOR: begin
        ex.x_we   = 1'b1;
        ex.x_data = logic_res;
        ex.f_we   = quirk.logic_clears_flag;
      end
      c8eu_pkg::FN_ADD: begin
        ex.x_we   = 1'b1;
        ex.x_data = sum[7:0];
        ex.f_we   = 1'b1;
        ex.f_data = {7'd0, sum[8]};
      end
      c8eu_pkg::FN_SUB: begin
        ex.x_we   = 1'b1;
        ex.x_data = opnd.vx - opnd.vy;
        ex.f_we   = 1'b1;
        ex.f_data = {7'd0, opnd.vx >= opnd.vy};
      end
      c8eu_pkg::FN_SUBN: begin
        ex.x_we   = 1'b1;
        ex.x_data = opnd.vy - opnd.vx;
        ex.f_we   = 1'b1;
        ex.f_data = {7'd0, opnd.vy >= opnd.vx};
      end
      c8eu_pkg::FN_SHR: begin
        ex.x_we   = 1'b1;
        ex.x_data = {1'b0, shift_src[7:1]};
        ex.f_we   = 1'b1;
        ex.f_data = {7'd0, shift_src[0]};
      end
      c8eu_pkg::FN_SHL: begin
        ex.x_we   = 1'b1;
        ex.x_data = {shift_src[6:0], 1'b0};
        ex.f_we   = 1'b1;
        ex.f_data = {7'd0, shift_src[7]};
      end
      c8eu_pkg::FN_LD_I: begin
        ex.index_next = {4'd0, instr.nnn};
      end
      c8eu_pkg::FN_JP_OFF: begin
        ex.pc_next = {8'd0, opnd.vj} + {4'd0, instr.nnn};
      end
      c8eu_pkg::FN_RND: begin
        ex.x_we   = 1'b1;
        ex.x_data = instr.rnd & instr.kk;
      end
      c8eu_pkg::FN_SKP: begin
        if (key_held) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_SKNP: begin
        if (!key_held) ex.pc_next = pc_skip;
      end
      c8eu_pkg::FN_GET_DT: begin
        ex.x_we   = 1'b1;
        ex.x_data = instr.dly;
      end
      c8eu_pkg::FN_SET_DT: begin
        ex.timer_write = c8eu_pkg::TMR_DELAY;
        ex.timer_value = opnd.vx;
      end
      c8eu_pkg::FN_SET_ST: begin
        ex.timer_write = c8eu_pkg::TMR_SOUND;
        ex.timer_value = opnd.vx;
      end
      c8eu_pkg::FN_ADD_I: begin
        ex.index_next = opnd.index + {8'd0, opnd.vx};
      end
      c8eu_pkg::FN_FONT: begin
        ex.index_next = {8'd0, opnd.vx} * c8eu_pkg::FONT_STRIDE;
      end
      c8eu_pkg::FN_BIG_FONT: begin
        ex.index_next = {8'd0, opnd.vx} * c8eu_pkg::BIG_FONT_STRIDE
                      + c8eu_pkg::BIG_FONT_BASE;
      end
      c8eu_pkg::FN_EXIT: begin
        ex.halt_set = 1'b1;
      end
      default: begin
        // Unused codes: advance the PC only.
      end
    endcase
  end

endmodule

// File: rtl/chip8_execute_unit.sv
// Top level of the CHIP-8 execute unit: register file, return stack and result channel.
//
// Executes one decoded CHIP-8 instruction per transaction and returns one result
// transaction holding PC, I, Vx, VF, a timer load and the halt flag after that
// instruction. Throughput is one instruction per cycle while results are taken. The
// instruction stage registers the instruction and launches reads of the V-register
// RAMs and the return-stack RAM; then decode and datapath run and load the result
// register. An instruction is taken while a result still waits; the two stages
// stall together only when the result register is full and not taken. V0..VE live
// in RAM with per-entry valid bits (an unwritten register reads 0), VF lives in a
// flip-flop, and a same-cycle write from the instruction ahead is forwarded into the
// operands. The stack holds STACK_DEPTH entries; a return from an empty stack pops
// the top entry, a call on a full stack restarts at entry 0. After exit, every later
// instruction changes nothing and reports the current values. Writing start_address
// also loads the PC. Configure only while no transaction is in flight.
module chip8_execute_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [c8eu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [c8eu_pkg::CFG_DATA_W-1:0]    cfg_data,
  c8eu_in_if.sink                            instr,
  c8eu_out_if.source                         result
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
  localparam logic [LW-1:0] LEVEL_ONE = LW'(1);

  // Configuration registers.
  logic        logic_clears_flag;
  logic        shift_uses_second;
  logic        offset_jump_uses_vx;
  logic [15:0] start_address;

  // Architectural state held in flip-flops.
  logic [15:0]   pc;
  logic [15:0]   index_reg;
  logic [7:0]    vf;
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic          halt_flag;
  logic [15:0]   reg_valid;

  // Instruction stage.
  logic             s_valid;
  c8eu_pkg::instr_t s_instr;
  logic [3:0]       s_jidx;
  logic             s_hx, s_hy, s_hj;
  logic             s_vldx, s_vldy, s_vldj;
  logic [7:0]       s_fwd;
  logic             s_hs;
  logic [15:0]      s_fwd_s;
  logic [AW-1:0]    s_pop_addr;

  // Handshake.
  logic in_fire;
  logic exec_fire;
  logic do_exec;
  logic out_valid;

  // Datapath.
  c8eu_pkg::instr_t    in_instr;
  c8eu_pkg::operands_t opnd;
  c8eu_pkg::quirk_t    quirk;
  c8eu_pkg::exec_t     ex;
  logic [3:0]          jaddr;
  logic [7:0]          ram_x, ram_y, ram_j;
  logic [15:0]         ram_s;
  logic [7:0]          rx, ry, rj;
  logic                x_we_now;
  logic                push_now;
  logic [LW-1:0]       push_lvl;
  logic [AW-1:0]       push_addr;
  logic [LW-1:0]       pop_lvl;
  logic [AW-1:0]       rd_addr_s;
  logic [7:0]          vf_after;
  logic [7:0]          dest_after;

  assign in_fire      = instr.valid && instr.ready;
  assign exec_fire    = s_valid && (!out_valid || result.ready);
  assign do_exec      = exec_fire && !halt_flag;
  assign instr.ready  = !s_valid || exec_fire;
  assign result.valid = out_valid;

  assign in_instr = '{func: instr.func, x: instr.first_reg, y: instr.second_reg,
                      kk: instr.imm_byte, nnn: instr.target_addr, rnd: instr.random_byte,
                      keys: instr.key_mask, dly: instr.delay_now};

  // Offset jump reads V0 or the register named by address bits 11:8.
  assign jaddr = offset_jump_uses_vx ? instr.target_addr[11:8] : c8eu_pkg::V0_INDEX;

  // Writes of the instruction executing at this edge, seen by the one loading now.
  assign x_we_now = do_exec && ex.x_we;
  assign push_now = do_exec && ex.push;

  // Return stack pointer: wrap a call on a full stack to entry 0.
  assign push_lvl  = (level >= DEPTH_L) ? '0 : level;
  assign push_addr = push_lvl[AW-1:0];

  always_comb begin
    level_next = level;
    if (push_now) begin
      level_next = push_lvl + LEVEL_ONE;
    end else if (do_exec && ex.pop) begin
      level_next = LW'(s_pop_addr);
    end
  end

  // Pop address as seen after the instruction ahead: an empty stack pops the top.
  assign pop_lvl   = (level_next == '0 || level_next > DEPTH_L) ? (DEPTH_L - LEVEL_ONE)
                                                                : (level_next - LEVEL_ONE);
  assign rd_addr_s = pop_lvl[AW-1:0];

  // V-register RAMs: one copy per read port, all written together.
  c8eu_ram #(.WIDTH(8), .DEPTH(16)) u_vram_x (
    .clk(clk), .we(x_we_now), .waddr(s_instr.x), .wdata(ex.x_data),
    .re(in_fire), .raddr(instr.first_reg), .rdata(ram_x)
  );
  c8eu_ram #(.WIDTH(8), .DEPTH(16)) u_vram_y (
    .clk(clk), .we(x_we_now), .waddr(s_instr.x), .wdata(ex.x_data),
    .re(in_fire), .raddr(instr.second_reg), .rdata(ram_y)
  );
  c8eu_ram #(.WIDTH(8), .DEPTH(16)) u_vram_j (
    .clk(clk), .we(x_we_now), .waddr(s_instr.x), .wdata(ex.x_data),
    .re(in_fire), .raddr(jaddr), .rdata(ram_j)
  );
  c8eu_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(push_now), .waddr(push_addr), .wdata(ex.push_data),
    .re(in_fire), .raddr(rd_addr_s), .rdata(ram_s)
  );

  // Instruction stage: register the instruction, forward hits and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (exec_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_instr    <= in_instr;
      s_jidx     <= jaddr;
      s_fwd      <= ex.x_data;
      s_hx       <= x_we_now && (s_instr.x == instr.first_reg);
      s_hy       <= x_we_now && (s_instr.x == instr.second_reg);
      s_hj       <= x_we_now && (s_instr.x == jaddr);
      s_vldx     <= reg_valid[instr.first_reg];
      s_vldy     <= reg_valid[instr.second_reg];
      s_vldj     <= reg_valid[jaddr];
      s_fwd_s    <= ex.push_data;
      s_hs       <= push_now && (push_addr == rd_addr_s);
      s_pop_addr <= rd_addr_s;
    end
  end

  // Operand select: forward, else RAM if written since reset, else zero; VF from its flop.
  assign rx = s_hx ? s_fwd : (s_vldx ? ram_x : 8'd0);
  assign ry = s_hy ? s_fwd : (s_vldy ? ram_y : 8'd0);
  assign rj = s_hj ? s_fwd : (s_vldj ? ram_j : 8'd0);

  assign opnd.vx     = (s_instr.x == c8eu_pkg::VF_INDEX) ? vf : rx;
  assign opnd.vy     = (s_instr.y == c8eu_pkg::VF_INDEX) ? vf : ry;
  assign opnd.vj     = (s_jidx == c8eu_pkg::VF_INDEX) ? vf : rj;
  assign opnd.pc     = pc;
  assign opnd.index  = index_reg;
  assign opnd.pop_pc = s_hs ? s_fwd_s : ram_s;

  assign quirk.logic_clears_flag = logic_clears_flag;
  assign quirk.shift_uses_second = shift_uses_second;

  c8eu_alu u_alu (
    .instr(s_instr),
    .opnd (opnd),
    .quirk(quirk),
    .ex   (ex)
  );

  // VF is written after Vx, so a flag write wins when x names VF.
  always_comb begin
    vf_after = vf;
    if (!halt_flag) begin
      if (ex.f_we) begin
        vf_after = ex.f_data;
      end else if (ex.x_we && s_instr.x == c8eu_pkg::VF_INDEX) begin
        vf_after = ex.x_data;
      end
    end
  end

  always_comb begin
    if (s_instr.x == c8eu_pkg::VF_INDEX) begin
      dest_after = vf_after;
    end else if (!halt_flag && ex.x_we) begin
      dest_after = ex.x_data;
    end else begin
      dest_after = rx;
    end
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      logic_clears_flag   <= 1'b1;
      shift_uses_second   <= 1'b0;
      offset_jump_uses_vx <= 1'b0;
      start_address       <= c8eu_pkg::START_ADDRESS_RESET;
      pc                  <= c8eu_pkg::START_ADDRESS_RESET;
      index_reg           <= '0;
      vf                  <= '0;
      level               <= '0;
      halt_flag           <= 1'b0;
      reg_valid           <= '0;
    end else begin
      if (do_exec) begin
        pc        <= ex.pc_next;
        index_reg <= ex.index_next;
        vf        <= vf_after;
        level     <= level_next;
        halt_flag <= halt_flag | ex.halt_set;
        if (ex.x_we) begin
          reg_valid[s_instr.x] <= 1'b1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          c8eu_pkg::CFG_LOGIC_CLEARS_FLAG:   logic_clears_flag   <= cfg_data[0];
          c8eu_pkg::CFG_SHIFT_USES_SECOND:   shift_uses_second   <= cfg_data[0];
          c8eu_pkg::CFG_OFFSET_JUMP_USES_VX: offset_jump_uses_vx <= cfg_data[0];
          c8eu_pkg::CFG_START_ADDRESS: begin
            start_address <= cfg_data;
            pc            <= cfg_data;
          end
        endcase
      end
    end
  end

  // Result register: load on execute, drop on transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result.next_pc     <= halt_flag ? pc : ex.pc_next;
      result.index_value <= halt_flag ? index_reg : ex.index_next;
      result.dest_value  <= dest_after;
      result.flag_value  <= vf_after;
      result.timer_write <= halt_flag ? c8eu_pkg::TMR_NONE : ex.timer_write;
      result.timer_value <= halt_flag ? 8'd0 : ex.timer_value;
      result.halted      <= halt_flag | ex.halt_set;
    end
  end

  // Stack level never leaves 0..STACK_DEPTH.
  a_level_range: assert property (@(posedge clk) disable iff (rst) level <= DEPTH_L)
    else $error("stack level out of range");

  // Once halted, the unit stays halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halt_flag |=> halt_flag)
    else $error("halt flag cleared");

  // A halted unit writes neither the register RAMs nor the stack.
  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
      halt_flag |-> (!x_we_now && !push_now))
    else $error("state write while halted");

  // An executed instruction always lands in the result register.
  a_exec_result: assert property (@(posedge clk) disable iff (rst) exec_fire |=> out_valid)
    else $error("executed instruction lost");

  // Call and return never come from the same instruction.
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
      s_valid |-> !(ex.push && ex.pop))
    else $error("push and pop together");

endmodule

// File: sim/chip8_execute_unit_test.sv
// Self-checking testbench for the CHIP-8 execute unit with a shadow machine model.
`timescale 1ns / 1ps

module chip8_execute_unit_test;
  import c8eu_pkg::*;

  localparam int STACK_ENTRIES = 16;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 290;
  localparam int SETTLE_CYCLES = 8;    // pipeline is two deep; leave margin
  localparam int BUSY_PCT      = 78;
  localparam int LIGHT_PCT     = 11;

  // Selector codes outside the operation list: they only advance the PC.
  localparam logic [4:0] FN_SPARE_LO = 5'd30;
  localparam logic [4:0] FN_SPARE_HI = 5'd31;

  // Machine values reported after one instruction.
  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] index_value;
    logic [7:0]  dest_value;
    logic [7:0]  flag_value;
    logic [1:0]  timer_write;
    logic [7:0]  timer_value;
    logic        halted;
  } machine_view_t;

  // Shadow copy of the execute unit: executes every accepted instruction and
  // keeps the machine views still owed by the block, oldest first.
  class chip8_shadow;
    logic [7:0]      vregs [16];
    logic [15:0]     ireg;
    logic [15:0]     pc_reg;
    logic [15:0]     calls [STACK_ENTRIES];
    bit              pushed [STACK_ENTRIES];
    int unsigned     depth;
    bit              stopped;
    bit              logic_clears_flag;
    bit              shift_uses_second;
    bit              offset_jump_uses_vx;
    machine_view_t   views_due [$];
    int unsigned     failures;

    function new();
      foreach (vregs[r]) vregs[r] = 8'h00;
      foreach (pushed[e]) pushed[e] = 1'b0;
      ireg = 16'h0000;
      pc_reg = START_ADDRESS_RESET;
      depth = 0;
      stopped = 1'b0;
      logic_clears_flag = 1'b1;
      shift_uses_second = 1'b0;
      offset_jump_uses_vx = 1'b0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOGIC_CLEARS_FLAG:   logic_clears_flag = data[0];
        CFG_SHIFT_USES_SECOND:   shift_uses_second = data[0];
        CFG_OFFSET_JUMP_USES_VX: offset_jump_uses_vx = data[0];
        CFG_START_ADDRESS: begin
          pc_reg = data;
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] reg_value(logic [3:0] r);
      return vregs[r];
    endfunction

    function int unsigned stack_level();
      return depth;
    endfunction

    // A return must only pop an entry that some call has filled.
    function bit may_return();
      return pushed[(depth == 0) ? STACK_ENTRIES - 1 : depth - 1];
    endfunction

    function int unsigned outstanding();
      return views_due.size();
    endfunction

    function void execute(instr_t it);
      machine_view_t view;
      logic [7:0]    vx;
      logic [7:0]    vy;
      logic [7:0]    sel;
      logic [8:0]    sum;
      logic [15:0]   pc;
      logic [1:0]    tw;
      logic [7:0]    tv;
      tw = TMR_NONE;
      tv = 8'h00;
      if (!stopped) begin
        vx = vregs[it.x];
        vy = vregs[it.y];
        sel = shift_uses_second ? vy : vx;
        pc = pc_reg + PC_STEP;
        case (it.func)
          FN_RET: begin
            if (depth == 0 || depth > STACK_ENTRIES) depth = STACK_ENTRIES;
            depth--;
            pc = calls[depth];
          end
          FN_JP: pc = {4'h0, it.nnn};
          FN_CALL: begin
            if (depth >= STACK_ENTRIES) depth = 0;
            calls[depth] = pc;
            pushed[depth] = 1'b1;
            depth++;
            pc = {4'h0, it.nnn};
          end
          FN_SE_IMM:  if (vx == it.kk) pc += PC_STEP;
          FN_SNE_IMM: if (vx != it.kk) pc += PC_STEP;
          FN_SE:      if (vx == vy) pc += PC_STEP;
          FN_SNE:     if (vx != vy) pc += PC_STEP;
          FN_LD_IMM:  vregs[it.x] = it.kk;
          FN_ADD_IMM: vregs[it.x] = vx + it.kk;
          FN_MOV:     vregs[it.x] = vy;
          FN_OR, FN_AND, FN_XOR: begin
            vregs[it.x] = (it.func == FN_OR) ? (vx | vy) :
                          (it.func == FN_AND) ? (vx & vy) : (vx ^ vy);
            if (logic_clears_flag) vregs[VF_INDEX] = 8'h00;
          end
          // Arithmetic and shifts write the flag last, so VF as Vx ends up
          // holding the flag.
          FN_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vregs[it.x] = sum[7:0];
            vregs[VF_INDEX] = {7'd0, sum[8]};
          end
          FN_SUB: begin
            vregs[it.x] = vx - vy;
            vregs[VF_INDEX] = {7'd0, vx >= vy};
          end
          FN_SUBN: begin
            vregs[it.x] = vy - vx;
            vregs[VF_INDEX] = {7'd0, vy >= vx};
          end
          FN_SHR: begin
            vregs[it.x] = sel >> 1;
            vregs[VF_INDEX] = {7'd0, sel[0]};
          end
          FN_SHL: begin
            vregs[it.x] = sel << 1;
            vregs[VF_INDEX] = {7'd0, sel[7]};
          end
          FN_LD_I: ireg = {4'h0, it.nnn};
          FN_JP_OFF: begin
            sel = offset_jump_uses_vx ? vregs[it.nnn[11:8]] : vregs[V0_INDEX];
            pc = {8'h00, sel} + {4'h0, it.nnn};
          end
          FN_RND:    vregs[it.x] = it.rnd & it.kk;
          // Keys above 15 do not exist and count as released.
          FN_SKP:    if (vx < KEY_COUNT && it.keys[vx[3:0]]) pc += PC_STEP;
          FN_SKNP:   if (!(vx < KEY_COUNT && it.keys[vx[3:0]])) pc += PC_STEP;
          FN_GET_DT: vregs[it.x] = it.dly;
          FN_SET_DT: begin
            tw = TMR_DELAY;
            tv = vx;
          end
          FN_SET_ST: begin
            tw = TMR_SOUND;
            tv = vx;
          end
          FN_ADD_I:    ireg = ireg + {8'h00, vx};
          FN_FONT:     ireg = {8'h00, vx} * FONT_STRIDE;
          FN_BIG_FONT: ireg = {8'h00, vx} * BIG_FONT_STRIDE + BIG_FONT_BASE;
          FN_EXIT:     stopped = 1'b1;
          default: ;
        endcase
        pc_reg = pc;
      end
      view.next_pc = pc_reg;
      view.index_value = ireg;
      view.dest_value = vregs[it.x];
      view.flag_value = vregs[VF_INDEX];
      view.timer_write = tw;
      view.timer_value = tv;
      view.halted = stopped;
      views_due.push_back(view);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        failures++;
      end
    endfunction

    function void compare_view(machine_view_t got);
      machine_view_t want;
      if (views_due.size() == 0) begin
        $error("result transaction with no instruction outstanding");
        failures++;
        return;
      end
      want = views_due.pop_front();
      check_field("next_pc", want.next_pc, got.next_pc);
      check_field("index_value", want.index_value, got.index_value);
      check_field("dest_value", {8'h00, want.dest_value}, {8'h00, got.dest_value});
      check_field("flag_value", {8'h00, want.flag_value}, {8'h00, got.flag_value});
      check_field("timer_write", {14'd0, want.timer_write}, {14'd0, got.timer_write});
      check_field("timer_value", {8'h00, want.timer_value}, {8'h00, got.timer_value});
      check_field("halted", {15'd0, want.halted}, {15'd0, got.halted});
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  c8eu_in_if  instr_ch ();
  c8eu_out_if result_ch ();

  chip8_shadow shadow;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  chip8_execute_unit #(.STACK_DEPTH(STACK_ENTRIES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .instr     (instr_ch),
    .result    (result_ch)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Build an instruction; operands the operation ignores get random values.
  function automatic instr_t make_instr(logic [4:0] f, logic [3:0] x, logic [3:0] y,
                                        logic [7:0] kk, logic [11:0] nnn);
    instr_t it;
    it.func = f;
    it.x = x;
    it.y = y;
    it.kk = kk;
    it.nnn = nnn;
    it.rnd = 8'($urandom);
    it.keys = 16'($urandom);
    it.dly = 8'($urandom);
    return it;
  endfunction

  // Random instruction. Exit is left out unless any_func is set, since a halt
  // freezes the machine for the rest of the run. Returns that would pop a
  // never-filled stack entry turn into calls.
  function automatic instr_t random_instr(bit any_func);
    instr_t     it;
    logic [4:0] f;
    if (any_func)
      f = 5'($urandom_range(FN_RET, FN_SPARE_HI));
    else if ($urandom_range(99) < 3)
      f = 5'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    else
      f = 5'($urandom_range(FN_RET, FN_BIG_FONT));
    if (f == FN_RET && !shadow.may_return()) f = FN_CALL;
    it = make_instr(f, 4'($urandom), 4'($urandom), 8'($urandom), 12'($urandom));
    // Steer operands so that skips, key tests and the key range edge get hit.
    case (f)
      FN_SE_IMM, FN_SNE_IMM: begin
        if ($urandom_range(1)) it.kk = shadow.reg_value(it.x);
      end
      FN_SE, FN_SNE: begin
        if ($urandom_range(3) == 0) it.y = it.x;
      end
      FN_LD_IMM: begin
        if ($urandom_range(1)) it.kk = 8'($urandom_range(0, 20));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Send one instruction transaction, with a random hold-off first, and hand
  // it to the shadow once it is accepted. Valid stays high on return.
  task automatic issue(instr_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    instr_ch.valid       <= 1'b1;
    instr_ch.func        <= it.func;
    instr_ch.first_reg   <= it.x;
    instr_ch.second_reg  <= it.y;
    instr_ch.imm_byte    <= it.kk;
    instr_ch.target_addr <= it.nnn;
    instr_ch.random_byte <= it.rnd;
    instr_ch.key_mask    <= it.keys;
    instr_ch.delay_now   <= it.dly;
    do @(posedge clk); while (!instr_ch.ready);
    shadow.execute(it);
  endtask

  // Drop valid and hold until every outstanding result has come back, then
  // let the pipeline settle.
  task automatic drain();
    instr_ch.valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one configuration register; the write enable stays high on return.
  task automatic put_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow.write_register(idx, data);
  endtask

  task automatic random_run(int count, bit any_func);
    repeat (count) begin
      // Now and then hold the sender until the block has fully drained.
      if ($urandom_range(199) == 0) drain();
      issue(random_instr(any_func));
    end
  endtask

  // Result side: check every accepted result transaction, then pick the next
  // ready value for the current stall rate.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        shadow.compare_view('{result_ch.next_pc, result_ch.index_value,
                              result_ch.dest_value, result_ch.flag_value,
                              result_ch.timer_write, result_ch.timer_value,
                              result_ch.halted});
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    instr_t      it;
    logic [2:0]  quirks;
    logic [15:0] start;

    shadow = new();
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_LOGIC_CLEARS_FLAG;
    cfg_data             <= '0;
    instr_ch.valid       <= 1'b0;
    instr_ch.func        <= FN_RET;
    instr_ch.first_reg   <= '0;
    instr_ch.second_reg  <= '0;
    instr_ch.imm_byte    <= '0;
    instr_ch.target_addr <= '0;
    instr_ch.random_byte <= '0;
    instr_ch.key_mask    <= '0;
    instr_ch.delay_now   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset configuration: PC starts at 512 and logic
    // operations clear VF.
    issue(make_instr(FN_LD_IMM, 0, 0, 8'hFF, 0));
    issue(make_instr(FN_LD_IMM, 1, 0, 8'h01, 0));
    issue(make_instr(FN_ADD, 0, 1, 0, 0));          // carry out of bit 7
    issue(make_instr(FN_LD_IMM, 2, 0, 8'hF0, 0));
    issue(make_instr(FN_ADD, 15, 2, 0, 0));         // VF as destination
    issue(make_instr(FN_SUB, 1, 2, 0, 0));          // borrow
    issue(make_instr(FN_SUBN, 15, 2, 0, 0));
    issue(make_instr(FN_SHL, 15, 2, 0, 0));
    issue(make_instr(FN_SHR, 2, 2, 0, 0));
    issue(make_instr(FN_OR, 3, 2, 0, 0));
    issue(make_instr(FN_XOR, 15, 2, 0, 0));
    issue(make_instr(FN_AND, 2, 3, 0, 0));
    issue(make_instr(FN_MOV, 4, 2, 0, 0));
    issue(make_instr(FN_SE_IMM, 0, 0, 8'h00, 0));
    issue(make_instr(FN_SNE_IMM, 0, 0, 8'hFF, 0));
    issue(make_instr(FN_SE, 0, 0, 0, 0));
    issue(make_instr(FN_SNE, 1, 2, 0, 0));
    issue(make_instr(FN_LD_I, 0, 0, 0, 12'hFFF));
    issue(make_instr(FN_ADD_I, 2, 0, 0, 0));
    issue(make_instr(FN_FONT, 1, 0, 0, 0));
    issue(make_instr(FN_BIG_FONT, 2, 0, 0, 0));
    issue(make_instr(FN_JP_OFF, 0, 0, 0, 12'hFFF));
    it = make_instr(FN_RND, 6, 0, 8'hFF, 0);
    it.rnd = 8'hFF;
    issue(it);
    it = make_instr(FN_GET_DT, 7, 0, 0, 0);
    it.dly = 8'hFF;
    issue(it);
    issue(make_instr(FN_SET_DT, 2, 0, 0, 0));
    issue(make_instr(FN_SET_ST, 1, 0, 0, 0));
    it = make_instr(FN_SKP, 0, 0, 0, 0);
    it.keys = 16'hFFFF;
    issue(it);
    it = make_instr(FN_SKNP, 0, 0, 0, 0);
    it.keys = 16'h0000;
    issue(it);
    issue(make_instr(FN_ADD_IMM, 5, 0, 8'h10, 0));
    it = make_instr(FN_SKP, 5, 0, 0, 0);            // key 16 is never held
    it.keys = 16'hFFFF;
    issue(it);
    issue(make_instr(FN_CALL, 0, 0, 0, 12'hFFF));
    issue(make_instr(FN_RET, 0, 0, 0, 0));
    issue(make_instr(FN_JP, 0, 0, 0, 12'h000));
    issue(make_instr(FN_SPARE_LO, 0, 0, 0, 0));
    issue(make_instr(FN_SPARE_HI, 0, 0, 0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      // Reconfigure only while idle; first two phases take the extremes.
      if (phase == 0) begin
        quirks = 3'b000;
        start  = 16'h0000;
      end else if (phase == 1) begin
        quirks = 3'b111;
        start  = 16'hFFFF;
      end else begin
        quirks = 3'($urandom);
        start  = 16'($urandom);
      end
      put_register(CFG_LOGIC_CLEARS_FLAG, {15'd0, quirks[0]});
      put_register(CFG_SHIFT_USES_SECOND, {15'd0, quirks[1]});
      put_register(CFG_OFFSET_JUMP_USES_VX, {15'd0, quirks[2]});
      put_register(CFG_START_ADDRESS, start);
      cfg_we <= 1'b0;

      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = BUSY_PCT;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = BUSY_PCT;
        end
        default: begin
          send_idle_pct  = LIGHT_PCT;
          recv_stall_pct = LIGHT_PCT;
        end
      endcase

      // Walk the return stack: enough calls to fill it and wrap past the top,
      // then return until empty and twice more to pop from the empty stack.
      repeat (STACK_ENTRIES + 1) issue(make_instr(FN_CALL, 0, 0, 0, 12'($urandom)));
      while (shadow.stack_level() != 0) issue(make_instr(FN_RET, 0, 0, 0, 0));
      repeat (2) issue(make_instr(FN_RET, 0, 0, 0, 0));

      random_run(PHASE_ITEMS, 1'b0);
    end

    // Halt the machine, then confirm that nothing moves afterwards.
    send_idle_pct  = LIGHT_PCT;
    recv_stall_pct = LIGHT_PCT;
    issue(make_instr(FN_EXIT, 4'($urandom), 4'($urandom), 8'($urandom), 12'($urandom)));
    random_run(20, 1'b1);

    drain();
    if (shadow.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
